// ===== sv/apm_pkg.sv =====
// Shared definitions for the approximate pattern matcher: operation codes,
// special pattern symbols, default sizes and the table command struct.
// No dependencies.
package apm_pkg;

   localparam int PATTERN_BITS_DEF  = 15;
   localparam int ALPHABET_SIZE_DEF = 256;
   localparam int MAX_ERRORS_DEF    = 3;

   localparam int SYM_W   = 8;
   localparam int OP_W    = 2;
   localparam int ERR_W   = 2;
   // error levels addressable by the 2-bit error register
   localparam int REPORT_LEVELS = 4;

   localparam logic [OP_W-1:0] OP_NEW_PATTERN = 2'd0;
   localparam logic [OP_W-1:0] OP_PATTERN     = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT        = 2'd2;

   localparam logic [SYM_W-1:0] SYM_SPACE   = 8'h20;
   localparam logic [SYM_W-1:0] SYM_OPEN    = 8'h03;
   localparam logic [SYM_W-1:0] SYM_CLOSE   = 8'h04;
   localparam logic [SYM_W-1:0] SYM_LOWER_A = 8'h61;
   localparam logic [SYM_W-1:0] SYM_LOWER_Z = 8'h7A;
   localparam logic [SYM_W-1:0] CASE_OFFSET = 8'h20;

   // control for the character table, one operation per cycle
   typedef struct packed {
      logic clear;     // new pattern: drop every entry
      logic mark;      // OR the position bits into the addressed entry
      logic read;      // text byte: fetch the addressed entry
      logic in_range;  // symbol lies inside the alphabet
   } tbl_cmd_type;

endpackage

// ===== sv/apm_char_table.sv =====
// Character table: per folded character, the pattern positions it may take.
// Memory with registered read, per-entry valid bits so a clear drops every entry.
// Depends on apm_pkg.
module apm_char_table #(
   parameter int PATTERN_BITS  = apm_pkg::PATTERN_BITS_DEF,
   parameter int ALPHABET_SIZE = apm_pkg::ALPHABET_SIZE_DEF,
   parameter int ADDR_W        = $clog2(ALPHABET_SIZE)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  apm_pkg::tbl_cmd_type    cmd,
   input  logic [ADDR_W-1:0]       addr,
   input  logic [PATTERN_BITS-1:0] wr_bits,
   output logic [PATTERN_BITS-1:0] rd_word
);
   import apm_pkg::*;

   logic [PATTERN_BITS-1:0]  table_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;
   logic [PATTERN_BITS-1:0]  rd_data_ff;
   logic                     rd_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.mark) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // first write after a clear replaces stale data, later ones set bits
   always_ff @(posedge clock) begin
      if (cmd.mark) begin
         if (!valid_ff[addr]) begin
            table_mem[addr] <= wr_bits;
         end else begin
            for (int j = 0; j < PATTERN_BITS; j++) begin
               if (wr_bits[j]) begin
                  table_mem[addr][j] <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= table_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_hit_ff <= 1'b0;
      end else if (cmd.read) begin
         rd_hit_ff <= valid_ff[addr] && cmd.in_range;
      end
   end

   assign rd_word = rd_hit_ff ? rd_data_ff : '0;

endmodule

// ===== sv/apm_level_step.sv =====
// One text-byte update of the error-level match vectors.
// Pure combinational; depends on apm_pkg for defaults.
module apm_level_step #(
   parameter int PATTERN_BITS = apm_pkg::PATTERN_BITS_DEF,
   parameter int MAX_ERRORS   = apm_pkg::MAX_ERRORS_DEF
) (
   input  logic [MAX_ERRORS:0][PATTERN_BITS-1:0] levels_cur,
   input  logic                                  new_text,
   input  logic [PATTERN_BITS-1:0]               char_bits,
   input  logic [PATTERN_BITS-1:0]               wild_bits,
   output logic [MAX_ERRORS:0][PATTERN_BITS-1:0] levels_next
);
   import apm_pkg::*;

   localparam logic [PATTERN_BITS-1:0] TOP_BIT = {1'b1, {(PATTERN_BITS-1){1'b0}}};

   logic [MAX_ERRORS:0][PATTERN_BITS-1:0] lv;
   logic [MAX_ERRORS:0][PATTERN_BITS-1:0] nv;

   always_comb begin
      lv = levels_cur;
      if (new_text) begin
         lv    = '0;
         lv[0] = TOP_BIT;
      end
      // match/wildcard per level, plus substitution and insertion from below
      for (int k = 0; k <= MAX_ERRORS; k++) begin
         nv[k] = (lv[k] & wild_bits) | ((lv[k] & char_bits) >> 1);
         if (k > 0) begin
            nv[k] = nv[k] | lv[k-1] | (lv[k-1] >> 1);
         end
      end
      // deletion: ripple the new lower level upward
      for (int k = 1; k <= MAX_ERRORS; k++) begin
         nv[k] = nv[k] | (nv[k-1] >> 1);
      end
      levels_next = nv;
   end

endmodule

// ===== sv/approximate_pattern_matcher.sv =====
// Top level of the approximate pattern matcher: compile control, text stage,
// result register. Depends on apm_pkg, apm_char_table and apm_level_step.
//
// Usage
//   req channel: one transfer per operation. tuser[1:0] selects new pattern,
//   pattern byte or text byte; tuser[2] on a text byte restarts the text.
//   tdata[7:0] carries the byte. Code 3 is accepted and dropped.
//   rsp channel: one transfer per text byte, tdata[0] = match within the
//   error budget; pattern operations produce nothing.
//   csr channel: allowed error count, always ready; write only while idle.
// Timing
//   A text byte is accepted and its table entry read into a register; when the
//   text stage can pass it on, the level vectors are updated and the result
//   registered, raising rsp_tvalid. Pattern bytes take effect at their
//   accepting edge. One transfer per cycle is sustained while rsp_tready stays
//   high; the limit is the single table read feeding the level update.
// Reset and stall
//   Reset empties the table (valid bits), returns the pattern to position 0
//   and clears the error register. When rsp_tready is low the result holds,
//   the text stage keeps one more byte, then req_tready drops.
module approximate_pattern_matcher #(
   parameter int PATTERN_BITS  = apm_pkg::PATTERN_BITS_DEF,
   parameter int ALPHABET_SIZE = apm_pkg::ALPHABET_SIZE_DEF,
   parameter int MAX_ERRORS    = apm_pkg::MAX_ERRORS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [apm_pkg::SYM_W-1:0] req_tdata,   // [7:0] symbol
   input  logic [2:0]              req_tuser,     // [1:0] op, [2] new_text
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,     // [0] matched, [7:1] zero
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [apm_pkg::ERR_W-1:0] csr_data     // [1:0] allowed_errors
);
   import apm_pkg::*;

   localparam int ADDR_W = $clog2(ALPHABET_SIZE);
   localparam logic [PATTERN_BITS-1:0] TOP_BIT = {1'b1, {(PATTERN_BITS-1){1'b0}}};

   // ---------------- input decode ----------------
   logic             req_accept;
   logic [OP_W-1:0]  req_op;
   logic             req_new_text;
   logic [SYM_W-1:0] req_sym;

   assign req_accept   = req_tvalid && req_tready;
   assign req_op       = req_tuser[OP_W-1:0];
   assign req_new_text = req_tuser[OP_W];
   assign req_sym      = req_tdata;

   // case folding: lower-case letters share the upper-case entry
   logic             sym_lower;
   logic             sym_in_range;
   logic [SYM_W-1:0] sym_folded;
   logic [ADDR_W-1:0] tbl_addr;

   assign sym_lower    = (req_sym >= SYM_LOWER_A) && (req_sym <= SYM_LOWER_Z);
   assign sym_in_range = {1'b0, req_sym} < (SYM_W+1)'(ALPHABET_SIZE);
   assign sym_folded   = sym_lower ? (req_sym - CASE_OFFSET) : req_sym;
   assign tbl_addr     = sym_folded[ADDR_W-1:0];

   // ---------------- pattern compile state ----------------
   logic [PATTERN_BITS-1:0] pos_ff, pos_in;
   logic [PATTERN_BITS-1:0] wild_ff, wild_in;
   logic                    in_class_ff, in_class_in;
   tbl_cmd_type             tbl_cmd;
   logic                    mark;

   always_comb begin
      pos_in      = pos_ff;
      wild_in     = wild_ff;
      in_class_in = in_class_ff;
      mark        = 1'b0;
      tbl_cmd     = '0;
      if (req_accept) begin
         case (req_op)
            OP_NEW_PATTERN: begin
               pos_in        = TOP_BIT;
               wild_in       = '0;
               in_class_in   = 1'b0;
               tbl_cmd.clear = 1'b1;
            end
            OP_PATTERN: begin
               if (in_class_ff) begin
                  if (req_sym == SYM_CLOSE) begin
                     in_class_in = 1'b0;
                     pos_in      = pos_ff >> 1;
                  end else begin
                     mark = 1'b1;
                  end
               end else if (req_sym == SYM_SPACE) begin
                  // wildcard holds the position, no advance
                  wild_in = wild_ff | pos_ff;
               end else if (req_sym == SYM_OPEN) begin
                  in_class_in = 1'b1;
               end else begin
                  mark   = 1'b1;
                  pos_in = pos_ff >> 1;
               end
            end
            OP_TEXT: begin
               tbl_cmd.read = 1'b1;
            end
            default: begin
            end
         endcase
      end
      tbl_cmd.mark     = mark && sym_in_range;
      tbl_cmd.in_range = sym_in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= TOP_BIT;
         wild_ff     <= '0;
         in_class_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         wild_ff     <= wild_in;
         in_class_ff <= in_class_in;
      end
   end

   logic [PATTERN_BITS-1:0] char_bits;

   apm_char_table #(
      .PATTERN_BITS  (PATTERN_BITS),
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .ADDR_W        (ADDR_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .addr    (tbl_addr),
      .wr_bits (pos_ff),
      .rd_word (char_bits)
   );

   // ---------------- text stage ----------------
   // holds one text byte whose table entry sits in the read register
   logic s1_valid_ff;
   logic s1_new_text_ff;
   logic s1_go;
   logic rsp_valid_ff;

   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= (req_op == OP_TEXT);
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_op == OP_TEXT)) begin
         s1_new_text_ff <= req_new_text;
      end
   end

   logic [MAX_ERRORS:0][PATTERN_BITS-1:0] levels_ff, levels_in, levels_step, levels_init;

   always_comb begin
      levels_init    = '0;
      levels_init[0] = TOP_BIT;
   end

   apm_level_step #(
      .PATTERN_BITS (PATTERN_BITS),
      .MAX_ERRORS   (MAX_ERRORS)
   ) u_step (
      .levels_cur  (levels_ff),
      .new_text    (s1_new_text_ff),
      .char_bits   (char_bits),
      .wild_bits   (wild_ff),
      .levels_next (levels_step)
   );

   // a new pattern accepted at the same edge comes later in order: it wins
   always_comb begin
      levels_in = levels_ff;
      if (req_accept && (req_op == OP_NEW_PATTERN)) begin
         levels_in = levels_init;
      end else if (s1_go) begin
         levels_in = levels_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= levels_init;
      end else begin
         levels_ff <= levels_in;
      end
   end

   // ---------------- error register ----------------
   logic [ERR_W-1:0] allowed_errors_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         allowed_errors_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         allowed_errors_ff <= csr_data;
      end
   end

   // levels beyond the configured maximum read as empty
   logic [REPORT_LEVELS-1:0][PATTERN_BITS-1:0] report_levels;

   for (genvar g = 0; g < REPORT_LEVELS; g++) begin : g_report
      if (g <= MAX_ERRORS) begin : g_used
         assign report_levels[g] = levels_step[g];
      end else begin : g_unused
         assign report_levels[g] = '0;
      end
   end

   logic match_in;
   assign match_in = |(report_levels[allowed_errors_ff] & pos_ff);

   // ---------------- result register ----------------
   logic rsp_matched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_matched_ff <= match_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_matched_ff};

   // ---------------- checks ----------------
   a_stall_only_when_busy : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a held result");

   a_text_enters_stage : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_TEXT)) |=> s1_valid_ff)
      else $error("accepted text byte lost before the level update");

   a_stage_to_result : assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("level update produced no result");

   a_new_pattern_resets : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_NEW_PATTERN)) |=>
         (pos_ff == TOP_BIT) && (wild_ff == '0) && (levels_ff[0] == TOP_BIT))
      else $error("new pattern did not restore compile state");

   a_position_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0(pos_ff))
      else $error("position vector holds more than one bit");

endmodule
